### design/mahd_pkg.sv
// ----------------------------------------------------------------------------
// MPEG audio header decode package
// Shared types, field codes, rate tables and divider constants.
// ----------------------------------------------------------------------------
package mahd_pkg;

  // Raw layer code that is reserved
  localparam logic [1:0] LAYER_RSVD = 2'd0;

  // Layer numbers after decoding
  localparam logic [1:0] LAYER_1 = 2'd1;
  localparam logic [1:0] LAYER_3 = 2'd3;

  // Version codes
  localparam logic [1:0] VER_MPEG1  = 2'd0;
  localparam logic [1:0] VER_MPEG2  = 2'd1;
  localparam logic [1:0] VER_MPEG25 = 2'd2;

  // Sample-rate index codes
  localparam logic [1:0] SIDX_44K1 = 2'd0;
  localparam logic [1:0] SIDX_48K  = 2'd1;
  localparam logic [1:0] SIDX_32K  = 2'd2;
  localparam logic [1:0] SIDX_RSVD = 2'd3;

  // Bitrate index codes that are not usable
  localparam logic [3:0] BIDX_FREE = 4'd0;
  localparam logic [3:0] BIDX_BAD  = 4'd15;

  localparam logic [1:0] MODE_MONO = 2'd3;

  localparam logic [10:0] SPF_LAYER1 = 11'd384;
  localparam logic [10:0] SPF_LSF_L3 = 11'd576;
  localparam logic [10:0] SPF_FULL   = 11'd1152;

  // Scaled numerator and reciprocal multiplier widths
  localparam int unsigned NUM_W  = 18;
  localparam int unsigned RCP_W  = 19;
  localparam int unsigned PROD_W = NUM_W + RCP_W;

  // ceil(2^24/49) and ceil(2^26/147): exact for numerators below 2^18
  localparam logic [RCP_W-1:0] RECIP_49  = 19'd342393;
  localparam logic [RCP_W-1:0] RECIP_147 = 19'd456523;
  localparam logic [RCP_W-1:0] RECIP_ONE = 19'd1;

  // Numerator coefficients: 12000 or 144000 over the base rate, reduced
  localparam logic [7:0] COEF_L1_44K1 = 8'd40;   // 40/147
  localparam logic [7:0] COEF_L1_48K  = 8'd1;    // 1/4
  localparam logic [7:0] COEF_L1_32K  = 8'd3;    // 3/8
  localparam logic [7:0] COEF_44K1    = 8'd160;  // 160/49
  localparam logic [7:0] COEF_48K     = 8'd3;    // 3/1
  localparam logic [7:0] COEF_32K     = 8'd9;    // 9/2

  typedef enum logic [2:0] {
    DIV_1   = 3'd0,
    DIV_2   = 3'd1,
    DIV_4   = 3'd2,
    DIV_8   = 3'd3,
    DIV_49  = 3'd4,
    DIV_147 = 3'd5
  } div_e;

  typedef struct packed {
    logic        ok;
    logic [1:0]  layer;
    logic [1:0]  ver;
    logic [8:0]  br;
    logic [15:0] sr;
    logic [1:0]  mode;
    logic [1:0]  mode_ext;
    logic        crc_absent;
    logic        pad;
  } hdr_t;

  typedef struct packed {
    logic [7:0] coeff;
    logic [1:0] shift_k;
    div_e       div;
  } div_ctl_t;

  localparam logic [8:0] KBPS_MPEG1 [0:3][0:15] = '{
    '{default: 9'd0},
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
  };

  localparam logic [8:0] KBPS_LSF [0:3][0:15] = '{
    '{default: 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  function automatic logic [8:0] kbps_lookup(input logic       lsf,
                                             input logic [1:0] layer,
                                             input logic [3:0] bidx);
    logic [8:0] rate;
    rate = lsf ? KBPS_LSF[layer][bidx] : KBPS_MPEG1[layer][bidx];
    return rate;
  endfunction

  // Base (MPEG-1) sampling rate for an index; lower versions shift it down
  function automatic logic [15:0] hz_base(input logic [1:0] sidx);
    logic [15:0] hz;
    unique case (sidx)
      SIDX_44K1: hz = 16'd44100;
      SIDX_48K:  hz = 16'd48000;
      SIDX_32K:  hz = 16'd32000;
      default:   hz = 16'd0;
    endcase
    return hz;
  endfunction

endpackage

### design/mpeg_audio_header_decode_unit.sv
// ----------------------------------------------------------------------------
// MPEG audio header decode unit
// Decodes one MPEG-1/2/2.5 audio frame header word into frame parameters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: header_word_i with in_valid_i; the unit holds in_stall_o
//   high when it cannot take an item. Output channel: one result item per
//   header on out_valid_o, held while out_stall_i is high.
//   Pipeline: four register stages (decode, numerator, reciprocal multiply,
//   result). Throughput: one item per cycle while the output is not stalled.
//   The frame length division is a constant reciprocal multiply per
//   sample-rate family, so no stage iterates.
//   Stall: each stage advances when the one after it is empty or moving, so
//   bubbles fill while the receiver stalls; in_stall_o rises only once every
//   stage holds an item and the output is stalled.
//   Reset: clears all valid bits; no item is in flight afterwards.
//   A rejected header (bad sync, reserved layer, free or bad bitrate,
//   reserved sample rate) still yields one item with every field zero.
// ----------------------------------------------------------------------------
module mpeg_audio_header_decode_unit import mahd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] header_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        header_valid_o,
  output logic [1:0]  layer_number_o,
  output logic [1:0]  version_code_o,
  output logic [8:0]  bitrate_kbps_o,
  output logic [15:0] sample_rate_hz_o,
  output logic [1:0]  channel_count_o,
  output logic [1:0]  channel_mode_o,
  output logic [1:0]  mode_extension_o,
  output logic        crc_absent_o,
  output logic        padding_flag_o,
  output logic [10:0] samples_per_frame_o,
  output logic [11:0] frame_body_bytes_o
);

  typedef struct packed {
    logic        header_valid;
    logic [1:0]  layer_number;
    logic [1:0]  version_code;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic [1:0]  channel_count;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
    logic        crc_absent;
    logic        padding_flag;
    logic [10:0] samples_per_frame;
    logic [11:0] frame_body_bytes;
  } result_t;

  logic              dec_ready, dec_valid, div_ready, div_valid, out_ready;
  hdr_t              dec_hdr, div_hdr;
  div_ctl_t          dec_ctl;
  div_e              div_sel;
  logic [PROD_W-1:0] div_prod;
  logic [11:0]       quot, quot_half, quot_pad;
  logic              is_layer1, is_half;
  logic              out_valid_q;
  result_t           res_d, res_q;

  mahd_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .ready_o       (dec_ready),
    .header_word_i (header_word_i),
    .valid_o       (dec_valid),
    .ready_i       (div_ready),
    .hdr_o         (dec_hdr),
    .ctl_o         (dec_ctl)
  );

  mahd_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (div_ready),
    .hdr_i   (dec_hdr),
    .ctl_i   (dec_ctl),
    .valid_o (div_valid),
    .ready_i (out_ready),
    .hdr_o   (div_hdr),
    .div_o   (div_sel),
    .prod_o  (div_prod)
  );

  assign in_stall_o = !dec_ready;

  // Take the quotient from the product: power-of-two divisors are a shift,
  // the reciprocal divisors drop the fraction bits of the multiplier.
  always_comb begin
    case (div_sel)
      DIV_1:   quot = div_prod[11:0];
      DIV_2:   quot = div_prod[12:1];
      DIV_4:   quot = div_prod[13:2];
      DIV_8:   quot = div_prod[14:3];
      DIV_49:  quot = div_prod[35:24];
      DIV_147: quot = {1'b0, div_prod[36:26]};
      default: quot = 12'd0;
    endcase
  end

  assign is_layer1 = (div_hdr.layer == LAYER_1);
  assign is_half   = (div_hdr.layer == LAYER_3) && (div_hdr.ver != VER_MPEG1);
  assign quot_half = is_half ? (quot >> 1) : quot;
  assign quot_pad  = quot_half + 12'(div_hdr.pad);

  always_comb begin
    res_d.header_valid   = 1'b1;
    res_d.layer_number   = div_hdr.layer;
    res_d.version_code   = div_hdr.ver;
    res_d.bitrate_kbps   = div_hdr.br;
    res_d.sample_rate_hz = div_hdr.sr;
    res_d.channel_count  = (div_hdr.mode == MODE_MONO) ? 2'd1 : 2'd2;
    res_d.channel_mode   = div_hdr.mode;
    res_d.mode_extension = div_hdr.mode_ext;
    res_d.crc_absent     = div_hdr.crc_absent;
    res_d.padding_flag   = div_hdr.pad;
    // Layer 1 counts in 4-byte slots; strip the 4 header bytes either way
    if (is_layer1) begin
      res_d.samples_per_frame = SPF_LAYER1;
      res_d.frame_body_bytes  = {quot_pad[9:0], 2'b00} - 12'd4;
    end else begin
      res_d.samples_per_frame = is_half ? SPF_LSF_L3 : SPF_FULL;
      res_d.frame_body_bytes  = quot_pad - 12'd4;
    end
    if (!div_hdr.ok) begin
      res_d = '0;
    end
  end

  // Output register: hold the item while the receiver stalls
  assign out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_valid && out_ready) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign header_valid_o      = res_q.header_valid;
  assign layer_number_o      = res_q.layer_number;
  assign version_code_o      = res_q.version_code;
  assign bitrate_kbps_o      = res_q.bitrate_kbps;
  assign sample_rate_hz_o    = res_q.sample_rate_hz;
  assign channel_count_o     = res_q.channel_count;
  assign channel_mode_o      = res_q.channel_mode;
  assign mode_extension_o    = res_q.mode_extension;
  assign crc_absent_o        = res_q.crc_absent;
  assign padding_flag_o      = res_q.padding_flag;
  assign samples_per_frame_o = res_q.samples_per_frame;
  assign frame_body_bytes_o  = res_q.frame_body_bytes;

  // Back-pressure only ever originates at the output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output item");

  // A rejected header carries no decoded content
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !header_valid_o) |->
      (bitrate_kbps_o == 9'd0 && sample_rate_hz_o == 16'd0 &&
       frame_body_bytes_o == 12'd0 && samples_per_frame_o == 11'd0 &&
       layer_number_o == 2'd0))
    else $error("rejected header item has non-zero fields");

  // An accepted header has a legal frame size in samples
  a_spf_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && header_valid_o) |->
      (samples_per_frame_o == SPF_LAYER1 || samples_per_frame_o == SPF_LSF_L3 ||
       samples_per_frame_o == SPF_FULL))
    else $error("illegal samples per frame");

  // An accepted header has a non-zero rate pair and layer
  a_rates_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && header_valid_o) |->
      (bitrate_kbps_o != 9'd0 && sample_rate_hz_o != 16'd0 &&
       layer_number_o != 2'd0))
    else $error("accepted header with missing rate or layer");

endmodule

### design/mahd_decode.sv
// ----------------------------------------------------------------------------
// MPEG audio header decode - field decode stage
// Checks sync and reserved codes, looks up rates, selects divider setup.
// ----------------------------------------------------------------------------
module mahd_decode import mahd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] header_word_i,
  output logic        valid_o,
  input  logic        ready_i,
  output hdr_t        hdr_o,
  output div_ctl_t    ctl_o
);

  logic       valid_q;
  hdr_t       hdr_d, hdr_q;
  div_ctl_t   ctl_d, ctl_q;
  logic [1:0] layer_code, sidx, ver, layer;
  logic [3:0] bidx;
  logic       ok, lsf;

  assign layer_code = header_word_i[18:17];
  assign bidx       = header_word_i[15:12];
  assign sidx       = header_word_i[11:10];

  always_comb begin
    ok = (&header_word_i[31:21]) && (layer_code != LAYER_RSVD) &&
         (bidx != BIDX_FREE) && (bidx != BIDX_BAD) && (sidx != SIDX_RSVD);
    layer = 2'd0 - layer_code;
    if (header_word_i[20]) begin
      ver = header_word_i[19] ? VER_MPEG1 : VER_MPEG2;
    end else begin
      ver = VER_MPEG25;
    end
    lsf = (ver != VER_MPEG1);

    hdr_d.ok         = 1'b1;
    hdr_d.layer      = layer;
    hdr_d.ver        = ver;
    hdr_d.br         = kbps_lookup(lsf, layer, bidx);
    hdr_d.sr         = hz_base(sidx) >> ver;
    hdr_d.mode       = header_word_i[7:6];
    hdr_d.mode_ext   = header_word_i[5:4];
    hdr_d.crc_absent = header_word_i[16];
    hdr_d.pad        = header_word_i[9];

    ctl_d.shift_k = ver;
    unique case (sidx)
      SIDX_44K1: begin
        ctl_d.coeff = (layer == LAYER_1) ? COEF_L1_44K1 : COEF_44K1;
        ctl_d.div   = (layer == LAYER_1) ? DIV_147 : DIV_49;
      end
      SIDX_48K: begin
        ctl_d.coeff = (layer == LAYER_1) ? COEF_L1_48K : COEF_48K;
        ctl_d.div   = (layer == LAYER_1) ? DIV_4 : DIV_1;
      end
      SIDX_32K: begin
        ctl_d.coeff = (layer == LAYER_1) ? COEF_L1_32K : COEF_32K;
        ctl_d.div   = (layer == LAYER_1) ? DIV_8 : DIV_2;
      end
      default: begin
        ctl_d.coeff = 8'd0;
        ctl_d.div   = DIV_1;
      end
    endcase

    // Drop everything on a rejected header
    if (!ok) begin
      hdr_d = '0;
      ctl_d = '0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      hdr_q <= hdr_d;
      ctl_q <= ctl_d;
    end
  end

  assign valid_o = valid_q;
  assign hdr_o   = hdr_q;
  assign ctl_o   = ctl_q;

endmodule

### design/mahd_divide.sv
// ----------------------------------------------------------------------------
// MPEG audio header decode - frame length divider
// Two stages: scaled numerator, then multiply by the divisor's reciprocal.
// ----------------------------------------------------------------------------
module mahd_divide import mahd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  hdr_t              hdr_i,
  input  div_ctl_t          ctl_i,
  output logic              valid_o,
  input  logic              ready_i,
  output hdr_t              hdr_o,
  output div_e              div_o,
  output logic [PROD_W-1:0] prod_o
);

  logic              va_q, vb_q, rdy_a, rdy_b;
  hdr_t              hdr_a_q, hdr_b_q;
  div_e              div_a_q, div_b_q;
  logic [16:0]       coef_br;
  logic [19:0]       scaled;
  logic [NUM_W-1:0]  num_d, num_q;
  logic [RCP_W-1:0]  recip;
  logic [PROD_W-1:0] prod_d, prod_q;

  // Stage A: numerator = coeff * bitrate * 2^k (below 2^18 for legal codes)
  assign coef_br = 17'(ctl_i.coeff) * 17'(hdr_i.br);
  assign scaled  = {3'b000, coef_br} << ctl_i.shift_k;
  assign num_d   = scaled[NUM_W-1:0];

  // Stage B: reciprocal multiply, power-of-two divisors pass through
  always_comb begin
    case (div_a_q)
      DIV_49:  recip = RECIP_49;
      DIV_147: recip = RECIP_147;
      default: recip = RECIP_ONE;
    endcase
  end
  assign prod_d = PROD_W'(num_q) * PROD_W'(recip);

  assign rdy_b   = !vb_q || ready_i;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy_a) begin
      hdr_a_q <= hdr_i;
      div_a_q <= ctl_i.div;
      num_q   <= num_d;
    end
    if (va_q && rdy_b) begin
      hdr_b_q <= hdr_a_q;
      div_b_q <= div_a_q;
      prod_q  <= prod_d;
    end
  end

  assign valid_o = vb_q;
  assign hdr_o   = hdr_b_q;
  assign div_o   = div_b_q;
  assign prod_o  = prod_q;

endmodule
